FILE: src/apt_pkg.sv
// ---------------------------------------------------------------------------
// apt_pkg - shared types and constants of the aging peer table
// Field widths, topic and status codes, sequencer states and the
// per-entry classification passed from the store to the sequencer.
// ---------------------------------------------------------------------------
package apt_pkg;

	localparam int MAC_W    = 48;
	localparam int TIME_W   = 32;
	localparam int ID_W     = 24;
	localparam int TOPIC_W  = 3;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 2;

	// results per resolve word are capped
	localparam int RESULT_LIMIT = 32;
	localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd45000;

	localparam logic [TOPIC_W-1:0] TOPIC_STATE  = 3'd5;
	localparam logic [TOPIC_W-1:0] TOPIC_BUTTON = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DRAIN
	} apt_state_t;

	// classification of the entry read back in stage 1
	typedef struct packed {
		logic live;   // used and not expired
		logic own;    // used, full address equals sender
		logic clash;  // live, other address, same low 24 bits
		logic match;  // live and selected by the resolve key
	} apt_hit_t;

endpackage

FILE: src/apt_store.sv
// ---------------------------------------------------------------------------
// apt_store - entry memory of the aging peer table
// Synchronous address/last-seen memory with registered read data, used bits in
// flops, and classification of the entry read against the current word.
// ---------------------------------------------------------------------------
module apt_store #(
	parameter int PEER_ENTRIES = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(PEER_ENTRIES)-1:0]    rd_idx,
	input  logic                               wr_en,
	input  logic [$clog2(PEER_ENTRIES)-1:0]    wr_idx,
	input  logic [apt_pkg::MAC_W-1:0]          wr_address,
	input  logic [apt_pkg::TIME_W-1:0]         wr_seen,
	input  logic [apt_pkg::MAC_W-1:0]          key_address,
	input  logic [apt_pkg::TIME_W-1:0]         key_now,
	input  logic [apt_pkg::TIME_W-1:0]         key_timeout,
	input  logic [apt_pkg::ID_W-1:0]           key_dest,
	input  logic                               key_all,
	output apt_pkg::apt_hit_t                  hit,
	output logic [apt_pkg::MAC_W-1:0]          rd_address
);
	import apt_pkg::*;

	localparam int ENTRY_W = MAC_W + TIME_W;

	logic [ENTRY_W-1:0]      mem_q [PEER_ENTRIES];
	logic [PEER_ENTRIES-1:0] used_q;
	logic [ENTRY_W-1:0]      rdata_s1;
	logic                    used_s1;
	logic [TIME_W-1:0]       seen_s1;
	logic [TIME_W-1:0]       age;
	logic                    same_addr;
	logic                    low_eq;
	logic                    live;

	// address and last-seen: plain RAM, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= {wr_address, wr_seen};
		end
		rdata_s1 <= mem_q[rd_idx];
	end

	// used bits cleared at reset; an unused entry's stale data is never looked at
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			used_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q[wr_idx] <= 1'b1;
			end
			used_s1 <= used_q[rd_idx];
		end
	end

	assign rd_address = rdata_s1[ENTRY_W-1:TIME_W];
	assign seen_s1    = rdata_s1[TIME_W-1:0];

	// wrapping age; timeout of zero makes everything expired
	assign age       = key_now - seen_s1;
	assign live      = used_s1 && (age < key_timeout);
	assign same_addr = (rd_address == key_address);
	assign low_eq    = (rd_address[ID_W-1:0] == key_address[ID_W-1:0]);

	always_comb begin
		hit.live  = live;
		hit.own   = used_s1 && same_addr;
		hit.clash = live && !same_addr && low_eq;
		hit.match = live && (key_all || (rd_address[ID_W-1:0] == key_dest));
	end

endmodule

FILE: src/aging_peer_table.sv
// ---------------------------------------------------------------------------
// aging_peer_table - peer table with aging, admit and resolve
// Admits uplink frames into a table of peers and resolves destinations
// to the unexpired peers that match.
// ---------------------------------------------------------------------------
// Every input word walks the whole table once: one entry is read from the
// synchronous entry memory per cycle while the output side does not hold
// the scan back; a new word is only accepted once the current one has left
// its holding register, back in idle. An admit word gives one result;
// a resolve word gives one result per unexpired peer that matches, in slot
// order, at most 32, or a single unknown-peer result. The last result of a
// word carries tlast. The table is cleared at reset through its used bits,
// so no clearing pass is needed and words are taken straight away. A
// result waits in a holding register until the next match (or the end of
// the scan) shows whether it is the last; the output register then lets
// the block start the next word while the final result still waits to be
// taken. The timeout register must only be written while the block is idle.
// ---------------------------------------------------------------------------
module aging_peer_table #(
	parameter int PEER_ENTRIES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: peer_timeout_ms
	input  logic                         cfg_wr_en,
	input  logic [apt_pkg::TIME_W-1:0]   cfg_wr_data,
	// input words
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [47:0] source_mac, [50:48] topic, [51] id_claim_matches,
	// [83:52] now_ms, [107:84] dest_id, [108] dest_all, [111:109] zero
	input  logic [111:0]                 s_axis_tdata,
	// [0] mode
	input  logic                         s_axis_tuser,
	// result words
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [47:0] peer_address, [52:48] slot_index, [55:53] zero
	output logic [55:0]                  m_axis_tdata,
	// [1:0] status
	output logic [apt_pkg::STATUS_W-1:0] m_axis_tuser,
	output logic                         m_axis_tlast
);
	import apt_pkg::*;

	localparam int IDX_W = $clog2(PEER_ENTRIES);
	localparam logic [IDX_W:0] PTR_END = (IDX_W + 1)'(PEER_ENTRIES);

	apt_state_t state_q, state_d;

	// timeout register
	logic [TIME_W-1:0] timeout_q;

	// current word
	logic               mode_q;
	logic [MAC_W-1:0]   mac_q;
	logic [TOPIC_W-1:0] topic_q;
	logic               claim_q;
	logic [TIME_W-1:0]  now_q;
	logic [ID_W-1:0]    dest_q;
	logic               all_q;

	// scan pointer and read stage
	logic [IDX_W:0]   ptr_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] rd_idx;
	logic             issue;
	logic             scan_done;
	apt_hit_t         hit;
	logic [MAC_W-1:0] rd_address;

	// admit accumulators
	logic             own_v_q;
	logic [IDX_W-1:0] own_idx_q;
	logic             free_v_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             clash_q;

	// admit decision
	logic              topic_ok;
	logic              have_slot;
	logic [IDX_W-1:0]  admit_slot;
	logic [STATUS_W-1:0] admit_status;
	logic              admit_ok;
	logic              wr_en;

	// resolve emission
	logic [CNT_W-1:0]    cnt_q;
	logic                take;
	logic                stall;
	logic                out_free;
	logic                move;

	// holding register
	logic                pend_v_q;
	logic [STATUS_W-1:0] pend_status_q;
	logic [MAC_W-1:0]    pend_addr_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic                pend_last_q;

	// output register
	logic                out_v_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [MAC_W-1:0]    out_addr_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_last_q;

	logic accept;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// -----------------------------------------------------------------------
	// entry store
	// -----------------------------------------------------------------------
	apt_store #(
		.PEER_ENTRIES(PEER_ENTRIES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_idx      (rd_idx),
		.wr_en       (wr_en),
		.wr_idx      (admit_slot),
		.wr_address  (mac_q),
		.wr_seen     (now_q),
		.key_address (mac_q),
		.key_now     (now_q),
		.key_timeout (timeout_q),
		.key_dest    (dest_q),
		.key_all     (all_q),
		.hit         (hit),
		.rd_address  (rd_address)
	);

	// -----------------------------------------------------------------------
	// scan control
	// -----------------------------------------------------------------------
	// a resolve match can only enter the holding register when the old one
	// can leave; otherwise the scan freezes and the stage-1 entry is re-read
	assign out_free = !out_v_q || m_axis_tready;
	assign take     = (state_q == ST_SCAN) && valid_s1 && mode_q && hit.match
	                  && (cnt_q < CNT_W'(RESULT_LIMIT));
	assign stall    = take && pend_v_q && !out_free;
	assign move     = pend_v_q && out_free && (take || (state_q == ST_DRAIN));

	assign issue     = (state_q == ST_SCAN) && (ptr_q != PTR_END) && !stall;
	assign rd_idx    = stall ? idx_s1 : ptr_q[IDX_W-1:0];
	assign scan_done = (state_q == ST_SCAN) && (ptr_q == PTR_END) && !valid_s1;

	// -----------------------------------------------------------------------
	// admit decision, taken in the finish cycle; the memory is only written
	// here, never during a scan, so reads and the write cannot collide
	// -----------------------------------------------------------------------
	assign topic_ok   = (topic_q == TOPIC_STATE) || (topic_q == TOPIC_BUTTON);
	assign have_slot  = own_v_q || free_v_q;
	assign admit_slot = own_v_q ? own_idx_q : free_idx_q;

	always_comb begin
		admit_status = STATUS_OK;
		if (!topic_ok || clash_q) begin
			admit_status = STATUS_INVALID;
		end else if (!have_slot) begin
			admit_status = STATUS_BUSY;
		end else if ((topic_q == TOPIC_STATE) && !claim_q) begin
			admit_status = STATUS_INVALID;
		end
	end

	assign admit_ok = (admit_status == STATUS_OK);
	assign wr_en    = (state_q == ST_FINISH) && !mode_q && admit_ok;

	// -----------------------------------------------------------------------
	// sequencer
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (move) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= s_axis_tuser;
			mac_q   <= s_axis_tdata[47:0];
			topic_q <= s_axis_tdata[50:48];
			claim_q <= s_axis_tdata[51];
			now_q   <= s_axis_tdata[83:52];
			dest_q  <= s_axis_tdata[107:84];
			all_q   <= s_axis_tdata[108];
		end
	end

	// pointer, read stage, counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			own_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			clash_q  <= 1'b0;
		end else begin
			if (accept) begin
				ptr_q    <= '0;
				cnt_q    <= '0;
				own_v_q  <= 1'b0;
				free_v_q <= 1'b0;
				clash_q  <= 1'b0;
			end else if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (!stall) begin
				valid_s1 <= issue;
			end
			if (take && !stall) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if ((state_q == ST_SCAN) && valid_s1 && !mode_q) begin
				if (hit.own && !own_v_q) begin
					own_v_q <= 1'b1;
				end
				if (!hit.live && !free_v_q) begin
					free_v_q <= 1'b1;
				end
				if (hit.clash) begin
					clash_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if ((state_q == ST_SCAN) && valid_s1 && !mode_q) begin
			if (hit.own && !own_v_q) begin
				own_idx_q <= idx_s1;
			end
			if (!hit.live && !free_v_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// holding register: a result stays here until its last flag is known
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (take && !stall) begin
			pend_v_q <= 1'b1;
		end else if ((state_q == ST_FINISH) && (!mode_q || (cnt_q == '0))) begin
			pend_v_q <= 1'b1;
		end else if (move) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !stall) begin
			pend_status_q <= STATUS_OK;
			pend_addr_q   <= rd_address;
			pend_slot_q   <= SLOT_W'(idx_s1);
			pend_last_q   <= 1'b0;
		end else if (state_q == ST_FINISH) begin
			pend_last_q <= 1'b1;
			if (!mode_q) begin
				pend_status_q <= admit_status;
				pend_addr_q   <= mac_q;
				pend_slot_q   <= admit_ok ? SLOT_W'(admit_slot) : '0;
			end else if (cnt_q == '0) begin
				pend_status_q <= STATUS_UNKNOWN;
				pend_addr_q   <= '0;
				pend_slot_q   <= '0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// output register
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_status_q <= pend_status_q;
			out_addr_q   <= pend_addr_q;
			out_slot_q   <= pend_slot_q;
			out_last_q   <= pend_last_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, out_slot_q, out_addr_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// -----------------------------------------------------------------------
	// checks
	// -----------------------------------------------------------------------
	// nothing may be waiting in the holding register when a new word comes in
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_v_q)
		else $error("holding register busy while idle");

	// the read stage only carries entries during a scan
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("read stage active outside scan");

	// result count never passes the cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RESULT_LIMIT))
		else $error("result count over limit");

	// a frozen scan keeps its stage-1 entry
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> valid_s1 && $stable(idx_s1))
		else $error("stage 1 lost during stall");

endmodule

FILE: sim/aging_peer_table_tb.sv
// ---------------------------------------------------------------------------
// aging_peer_table_tb - self-checking bench for the aging peer table
// Drives admit and resolve words on the input stream and keeps its own model
// of the peer table: used bits, addresses, last-seen times and the timeout.
// Every result word is matched against that model in order. Directed words
// cover the topic rules, id claims, address clashes, expiry at the timeout
// edge, wrapping time and timeout extremes. Randomised words then fill the
// table, hold the output back for a long stretch, and run mixed traffic
// under several timeouts, with random gaps on both sides.
// ---------------------------------------------------------------------------
module aging_peer_table_tb;
	import apt_pkg::*;

	localparam bit MODE_ADMIT   = 1'b0;
	localparam bit MODE_RESOLVE = 1'b1;
	localparam int TABLE_SLOTS  = 32;
	// one full table walk plus margin
	localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;

	typedef struct {
		bit               resolve;
		logic [MAC_W-1:0] source_mac;
		logic [2:0]       topic;
		bit               id_claim_ok;
		logic [31:0]      now_ms;
		logic [23:0]      dest_id;
		bit               dest_all;
	} peer_req_t;

	typedef struct {
		logic [1:0]       status;
		logic [MAC_W-1:0] peer_address;
		logic [4:0]       slot_index;
		bit               is_last;
	} peer_res_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wr_en;
	logic [31:0]  cfg_wr_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	// model of the peer table
	bit               tbl_used [TABLE_SLOTS];
	logic [MAC_W-1:0] tbl_mac  [TABLE_SLOTS];
	logic [31:0]      tbl_seen [TABLE_SLOTS];
	logic [31:0]      tbl_timeout;

	peer_res_t        expected_results[$];
	peer_res_t        want;
	logic [MAC_W-1:0] mac_pool [16];
	logic [31:0]      clock_ms;

	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_cycles;
	int error_count;
	int words_admit;
	int words_resolve;
	int results_seen;
	int burst_len;
	int burst_max;
	int input_stalls;
	int status_seen [4];

	aging_peer_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("aging_peer_table_tb failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// table model
	// ---------------------------------------------------------------
	function automatic bit entry_live(int i, logic [31:0] now_ms);
		logic [31:0] age;
		age = now_ms - tbl_seen[i];
		return tbl_used[i] && (age < tbl_timeout);
	endfunction

	task automatic predict_word(input peer_req_t w);
		int i;
		int slot;
		int n;
		int k;
		bit have;
		bit clash;
		peer_res_t r;
		if (w.resolve == MODE_ADMIT) begin
			r.status       = STATUS_OK;
			r.peer_address = w.source_mac;
			r.slot_index   = '0;
			r.is_last      = 1'b1;
			have  = 1'b0;
			clash = 1'b0;
			slot  = 0;
			if (w.topic != TOPIC_STATE && w.topic != TOPIC_BUTTON) begin
				r.status = STATUS_INVALID;
			end else begin
				// own slot counts even when expired
				for (i = 0; i < TABLE_SLOTS; i++)
					if (!have && tbl_used[i] && tbl_mac[i] == w.source_mac) begin
						slot = i;
						have = 1'b1;
					end
				for (i = 0; i < TABLE_SLOTS; i++)
					if (entry_live(i, w.now_ms) && tbl_mac[i] != w.source_mac &&
							tbl_mac[i][23:0] == w.source_mac[23:0])
						clash = 1'b1;
				if (!have)
					for (i = 0; i < TABLE_SLOTS; i++)
						if (!have && !entry_live(i, w.now_ms)) begin
							slot = i;
							have = 1'b1;
						end
				if (clash)
					r.status = STATUS_INVALID;
				else if (!have)
					r.status = STATUS_BUSY;
				else if (w.topic == TOPIC_STATE && !w.id_claim_ok)
					r.status = STATUS_INVALID;
				else begin
					tbl_used[slot] = 1'b1;
					tbl_mac[slot]  = w.source_mac;
					tbl_seen[slot] = w.now_ms;
					r.slot_index   = slot[4:0];
				end
			end
			expected_results.push_back(r);
		end else begin
			n = 0;
			for (i = 0; i < TABLE_SLOTS; i++)
				if (entry_live(i, w.now_ms) && (w.dest_all || tbl_mac[i][23:0] == w.dest_id))
					n++;
			if (n > RESULT_LIMIT)
				n = RESULT_LIMIT;
			if (n == 0) begin
				r.status       = STATUS_UNKNOWN;
				r.peer_address = '0;
				r.slot_index   = '0;
				r.is_last      = 1'b1;
				expected_results.push_back(r);
			end else begin
				k = 0;
				for (i = 0; i < TABLE_SLOTS && k < n; i++)
					if (entry_live(i, w.now_ms) &&
							(w.dest_all || tbl_mac[i][23:0] == w.dest_id)) begin
						k++;
						r.status       = STATUS_OK;
						r.peer_address = tbl_mac[i];
						r.slot_index   = i[4:0];
						r.is_last      = (k == n);
						expected_results.push_back(r);
					end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// word builders; unused fields carry random bits
	// ---------------------------------------------------------------
	function automatic logic [MAC_W-1:0] rand_mac();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	function automatic peer_req_t admit_req(logic [MAC_W-1:0] mac, logic [2:0] topic,
			bit claim_ok, logic [31:0] now_ms);
		peer_req_t w;
		w.resolve     = MODE_ADMIT;
		w.source_mac  = mac;
		w.topic       = topic;
		w.id_claim_ok = claim_ok;
		w.now_ms      = now_ms;
		w.dest_id     = 24'($urandom());
		w.dest_all    = 1'($urandom());
		return w;
	endfunction

	function automatic peer_req_t resolve_req(logic [23:0] dest_id, bit dest_all,
			logic [31:0] now_ms);
		peer_req_t w;
		w.resolve     = MODE_RESOLVE;
		w.source_mac  = rand_mac();
		w.topic       = 3'($urandom());
		w.id_claim_ok = 1'($urandom());
		w.now_ms      = now_ms;
		w.dest_id     = dest_id;
		w.dest_all    = dest_all;
		return w;
	endfunction

	// ---------------------------------------------------------------
	// stream drivers
	// ---------------------------------------------------------------
	// valid is left high after acceptance; the next call lowers it only for a gap
	task automatic send_word(input peer_req_t w);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, w.dest_all, w.dest_id, w.now_ms, w.id_claim_ok,
			w.topic, w.source_mac};
		s_axis_tuser  <= w.resolve;
		do @(posedge clk); while (!s_axis_tready);
		predict_word(w);
		if (w.resolve == MODE_ADMIT)
			words_admit++;
		else
			words_resolve++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tbl_timeout = value;
	endtask

	// result side: random stalls, plus a long hold when asked
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 11) : 0;
			if (rx_hold_cycles > 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			input_stalls++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			status_seen[m_axis_tuser]++;
			burst_len++;
			if (m_axis_tlast) begin
				if (burst_len > burst_max)
					burst_max = burst_len;
				burst_len = 0;
			end
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: status %0d address %h",
					m_axis_tuser, m_axis_tdata[47:0]);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[47:0] !== want.peer_address) begin
					$error("peer_address: expected %h, got %h",
						want.peer_address, m_axis_tdata[47:0]);
					error_count++;
				end
				if (m_axis_tdata[52:48] !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						want.slot_index, m_axis_tdata[52:48]);
					error_count++;
				end
				if (m_axis_tlast !== want.is_last) begin
					$error("last: expected %0d, got %0d", want.is_last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	localparam logic [MAC_W-1:0] MAC_A     = 48'hA5A5_5AC0_FFEE;
	localparam logic [MAC_W-1:0] MAC_CLASH = {24'h123456, MAC_A[23:0]};

	task automatic test_empty_table();
		send_word(resolve_req(24'h000000, 1'b0, 32'h0000_0000));
		send_word(resolve_req(24'hFFFFFF, 1'b1, 32'hFFFF_FFFF));
	endtask

	task automatic test_admit_rules();
		int t;
		// every topic code; only state and button get in, button refreshes the slot
		for (t = 0; t < 8; t++)
			send_word(admit_req(MAC_A, 3'(t), 1'b1, 32'hFFFF_FFF0));
		// state frame with a bad id claim, table left alone
		send_word(admit_req(48'h0000_0012_3456, TOPIC_STATE, 1'b0, 32'hFFFF_FFF8));
		// button ignores the claim
		send_word(admit_req(48'hFFFF_FFFF_FFFF, TOPIC_BUTTON, 1'b0, 32'hFFFF_FFFC));
		// time wrapped past zero
		send_word(admit_req(48'h0, TOPIC_STATE, 1'b1, 32'h0000_0010));
		// same low 24 bits as a live peer
		send_word(admit_req(MAC_CLASH, TOPIC_BUTTON, 1'b1, 32'h0000_0010));
		send_word(resolve_req(MAC_A[23:0], 1'b0, 32'h0000_0020));
		send_word(resolve_req(24'hFFFFFF, 1'b0, 32'h0000_0020));
		send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0020));
	endtask

	task automatic test_expiry();
		// ages just under and exactly at the default timeout
		send_word(resolve_req(MAC_A[23:0], 1'b0, 32'hFFFF_FFF0 + 32'd44999));
		send_word(resolve_req(MAC_A[23:0], 1'b0, 32'hFFFF_FFF0 + 32'd45000));
		write_timeout(32'd1);
		send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0010));
		// zero timeout: nothing is live, the clash no longer blocks
		write_timeout(32'd0);
		send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0010));
		send_word(admit_req(MAC_CLASH, TOPIC_STATE, 1'b1, 32'h0000_0010));
		write_timeout(32'hFFFF_FFFF);
		send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0010));
	endtask

	task automatic test_table_full();
		int k;
		logic [MAC_W-1:0] mac;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// distinct low bits so the fill runs into busy rather than clashes
		for (k = 0; k < 34; k++) begin
			mac = rand_mac();
			mac[4:0] = k[4:0];
			mac[5]   = (k >= 32);
			send_word(admit_req(mac, $urandom_range(0, 1) ? TOPIC_STATE : TOPIC_BUTTON,
				1'b1, 32'h0000_0100 + k));
		end
		send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0200));
		send_word(admit_req(rand_mac(), TOPIC_BUTTON, 1'b1, 32'h0000_0201));
		send_word(resolve_req(mac[23:0], 1'b0, 32'h0000_0202));
	endtask

	task automatic test_backpressure();
		int k;
		// output held back while words keep coming: the block must stall its input
		wait_idle();
		rx_hold_cycles = 400;
		tx_idle_on     = 1'b0;
		for (k = 0; k < 10; k++) begin
			if (k % 3 == 2)
				send_word(admit_req(rand_mac(), TOPIC_BUTTON, 1'b1, 32'h0000_0300));
			else
				send_word(resolve_req(24'h000000, 1'b1, 32'h0000_0300 + k));
		end
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random();
		int phase;
		int k;
		int pick;
		int jump;
		logic [31:0] to_ms;
		logic [MAC_W-1:0] mac;
		// pool with pairs sharing low 24 bits, to provoke clashes
		for (k = 0; k < 16; k++) begin
			mac_pool[k] = rand_mac();
			if (k % 4 == 3)
				mac_pool[k][23:0] = mac_pool[k - 1][23:0];
		end
		clock_ms = $urandom();
		for (phase = 0; phase < 4; phase++) begin
			to_ms = (phase == 0) ? TIMEOUT_RESET : $urandom_range(16, 4000);
			write_timeout(to_ms);
			// one phase runs flat out on both sides
			tx_idle_on = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
			rx_idle_on = (phase == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
			for (k = 0; k < 16; k++) begin
				jump = $urandom_range(0, 19);
				if (jump == 0)
					clock_ms = $urandom();
				else if (jump < 3)
					clock_ms += $urandom_range(to_ms / 2, to_ms * 2);
				else
					clock_ms += $urandom_range(0, to_ms / 4);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_word(admit_req(mac_pool[$urandom_range(0, 15)],
						$urandom_range(0, 1) ? TOPIC_STATE : TOPIC_BUTTON, 1'b1, clock_ms));
				end else if (pick < 65) begin
					mac = $urandom_range(0, 1) ? rand_mac() : mac_pool[$urandom_range(0, 15)];
					send_word(admit_req(mac, 3'($urandom()), 1'($urandom()), clock_ms));
				end else if (pick < 75) begin
					send_word(resolve_req(24'($urandom()), 1'b0, clock_ms));
				end else if (pick < 88) begin
					send_word(resolve_req(mac_pool[$urandom_range(0, 15)][23:0], 1'b0,
						clock_ms));
				end else begin
					send_word(resolve_req(24'($urandom()), 1'b1, clock_ms));
				end
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		int i;
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		rx_hold_cycles = 0;
		error_count    = 0;
		words_admit    = 0;
		words_resolve  = 0;
		results_seen   = 0;
		burst_len      = 0;
		burst_max      = 0;
		input_stalls   = 0;
		for (i = 0; i < 4; i++)
			status_seen[i] = 0;
		tbl_timeout = TIMEOUT_RESET;
		for (i = 0; i < TABLE_SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_mac[i]  = '0;
			tbl_seen[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_admit_rules();
		test_expiry();
		test_table_full();
		test_backpressure();
		test_random();

		wait_idle();
		$display("covered %0d admit and %0d resolve words, %0d results, longest burst %0d",
			words_admit, words_resolve, results_seen, burst_max);
		$display("status ok/invalid/busy/unknown: %0d/%0d/%0d/%0d, input stall cycles %0d",
			status_seen[STATUS_OK], status_seen[STATUS_INVALID], status_seen[STATUS_BUSY],
			status_seen[STATUS_UNKNOWN], input_stalls);
		if (error_count == 0)
			$display("aging_peer_table_tb passed");
		else
			$display("aging_peer_table_tb failed");
		$finish;
	end

endmodule
